FILE: hw/rtl/frt_pkg.sv
// Shared constants, result codes and controller/datapath interface types.
package frt_pkg;

	localparam int TABLE_DEPTH  = 20;
	localparam int MAX_FRAGMENT = 16384;
	localparam int IDX_W        = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
	localparam int SLOT_W       = 6;
	localparam int ID_W         = 64;
	localparam int SIZE_W       = 32;
	localparam int LEN_W        = 15;
	localparam int STATUS_W     = 3;

	localparam logic FUNC_HEADER = 1'b0;
	localparam logic FUNC_FRAG   = 1'b1;

	localparam logic [STATUS_W-1:0] ST_OPENED   = 3'd0;
	localparam logic [STATUS_W-1:0] ST_DUP      = 3'd1;
	localparam logic [STATUS_W-1:0] ST_PARTIAL  = 3'd2;
	localparam logic [STATUS_W-1:0] ST_COMPLETE = 3'd3;
	localparam logic [STATUS_W-1:0] ST_UNKNOWN  = 3'd4;
	localparam logic [STATUS_W-1:0] ST_OOB      = 3'd5;

	typedef struct packed {
		logic             load;
		logic             scan;
		logic [IDX_W-1:0] idx;
		logic             eval;
		logic             commit;
	} cmd_t;

	typedef struct packed {
		logic out_free;
	} sts_t;

endpackage

FILE: hw/rtl/frt_ctrl.sv
// Sequencer: accept, scan the table, evaluate, commit the result.
module frt_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_ready,
	input  frt_pkg::sts_t sts,
	output frt_pkg::cmd_t cmd
);
	import frt_pkg::*;

	typedef enum logic [1:0] {IDLE, SCAN, EVAL, COMMIT} state_t;

	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_DEPTH - 1);

	state_t           state_q;
	logic [IDX_W-1:0] idx_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= IDLE;
			idx_q   <= '0;
		end else begin
			case (state_q)
				IDLE: begin
					if (in_valid) begin
						state_q <= SCAN;
						idx_q   <= '0;
					end
				end
				SCAN: begin
					if (idx_q == LAST_IDX) begin
						state_q <= EVAL;
					end else begin
						idx_q <= idx_q + 1'b1;
					end
				end
				EVAL: begin
					state_q <= COMMIT;
				end
				COMMIT: begin
					// hold until the output register can take the result
					if (sts.out_free) begin
						state_q <= IDLE;
					end
				end
				default: begin
					state_q <= IDLE;
				end
			endcase
		end
	end

	assign in_ready   = (state_q == IDLE);
	assign cmd.load   = (state_q == IDLE) && in_valid;
	assign cmd.scan   = (state_q == SCAN);
	assign cmd.idx    = idx_q;
	assign cmd.eval   = (state_q == EVAL);
	assign cmd.commit = (state_q == COMMIT) && sts.out_free;

endmodule

FILE: hw/rtl/frt_datapath.sv
// Entry table, scan trackers, bounds/count arithmetic and the result register.
module frt_datapath (
	input  logic                            clk,
	input  logic                            arst_n,
	input  frt_pkg::cmd_t                   cmd,
	output frt_pkg::sts_t                   sts,
	input  logic                            func,
	input  logic [frt_pkg::ID_W-1:0]        msg_id,
	input  logic [frt_pkg::SIZE_W-1:0]      total_size,
	input  logic [frt_pkg::SIZE_W-1:0]      frag_offset,
	input  logic [frt_pkg::LEN_W-1:0]       payload_len,
	output logic                            out_valid,
	input  logic                            out_ready,
	output logic [frt_pkg::STATUS_W-1:0]    status,
	output logic [frt_pkg::SLOT_W-1:0]      slot,
	output logic [frt_pkg::SIZE_W-1:0]      write_offset,
	output logic                            evicted,
	output logic [frt_pkg::ID_W-1:0]        evicted_id,
	output logic [frt_pkg::SIZE_W-1:0]      filled_count,
	output logic [frt_pkg::SIZE_W-1:0]      message_size
);
	import frt_pkg::*;

	// table
	logic [TABLE_DEPTH-1:0] valid_q;
	logic [ID_W-1:0]        id_mem_q     [TABLE_DEPTH];
	logic [SIZE_W-1:0]      size_mem_q   [TABLE_DEPTH];
	logic [SIZE_W-1:0]      filled_mem_q [TABLE_DEPTH];

	// latched item
	logic              func_q;
	logic [ID_W-1:0]   id_q;
	logic [SIZE_W-1:0] tsize_q;
	logic [SIZE_W-1:0] foff_q;
	logic [LEN_W-1:0]  plen_q;

	// scan trackers
	logic              match_found_q;
	logic [IDX_W-1:0]  match_idx_q;
	logic              min_found_q;
	logic [IDX_W-1:0]  min_idx_q;
	logic [ID_W-1:0]   min_id_q;

	// evaluation results
	logic              evict_q;
	logic              hit_q;
	logic              oob_q;
	logic [IDX_W-1:0]  free_idx_q;
	logic [SIZE_W:0]   sum_q;
	logic [SIZE_W-1:0] size_q;
	logic [SIZE_W-1:0] filled_q;

	// result register
	logic                out_valid_q;
	logic [STATUS_W-1:0] status_q;
	logic [SLOT_W-1:0]   slot_q;
	logic [SIZE_W-1:0]   woff_q;
	logic                evicted_q;
	logic [ID_W-1:0]     evid_q;
	logic [SIZE_W-1:0]   filled_out_q;
	logic [SIZE_W-1:0]   size_out_q;

	logic              full;
	logic              evict_c;
	logic              hit_c;
	logic [IDX_W-1:0]  first_free;
	logic [SIZE_W:0]   end_c;
	logic [SIZE_W-1:0] nf_c;
	logic              done_c;

	assign full    = &valid_q;
	assign evict_c = (func_q == FUNC_HEADER) && full && min_found_q;
	assign hit_c   = match_found_q && !(evict_c && (match_idx_q == min_idx_q));

	always_comb begin
		first_free = '0;
		for (int i = TABLE_DEPTH - 1; i >= 0; i--) begin
			if (!valid_q[i]) begin
				first_free = IDX_W'(i);
			end
		end
	end

	assign end_c  = {1'b0, foff_q} + {{(SIZE_W + 1 - LEN_W){1'b0}}, plen_q};
	assign nf_c   = sum_q[SIZE_W] ? '1 : sum_q[SIZE_W-1:0];
	assign done_c = (nf_c >= size_q);

	// input latch
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			func_q  <= func;
			id_q    <= msg_id;
			tsize_q <= total_size;
			foff_q  <= frag_offset;
			plen_q  <= payload_len;
		end
	end

	// scan: track the matching slot and the smallest valid id
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			match_found_q <= 1'b0;
			min_found_q   <= 1'b0;
		end else if (cmd.load) begin
			match_found_q <= 1'b0;
			min_found_q   <= 1'b0;
		end else if (cmd.scan && valid_q[cmd.idx]) begin
			if (!match_found_q && (id_mem_q[cmd.idx] == id_q)) begin
				match_found_q <= 1'b1;
			end
			if (!min_found_q || (id_mem_q[cmd.idx] < min_id_q)) begin
				min_found_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.scan && valid_q[cmd.idx]) begin
			if (!match_found_q && (id_mem_q[cmd.idx] == id_q)) begin
				match_idx_q <= cmd.idx;
			end
			if (!min_found_q || (id_mem_q[cmd.idx] < min_id_q)) begin
				min_idx_q <= cmd.idx;
				min_id_q  <= id_mem_q[cmd.idx];
			end
		end
	end

	// evaluate: eviction and hit decision, free slot, bounds check and running sum
	always_ff @(posedge clk) begin
		if (cmd.eval) begin
			evict_q    <= evict_c;
			hit_q      <= hit_c;
			free_idx_q <= evict_c ? min_idx_q : first_free;
			size_q     <= size_mem_q[match_idx_q];
			filled_q   <= filled_mem_q[match_idx_q];
			oob_q      <= ({{(SIZE_W - LEN_W){1'b0}}, plen_q} > SIZE_W'(MAX_FRAGMENT)) ||
			              (end_c > {1'b0, size_mem_q[match_idx_q]});
			sum_q      <= {1'b0, filled_mem_q[match_idx_q]} +
			              {{(SIZE_W + 1 - LEN_W){1'b0}}, plen_q};
		end
	end

	// commit: table valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else if (cmd.commit) begin
			if (func_q == FUNC_HEADER) begin
				if (hit_q) begin
					if (evict_q) begin
						valid_q[min_idx_q] <= 1'b0;
					end
				end else begin
					// an eviction frees exactly the slot that is refilled
					valid_q[free_idx_q] <= 1'b1;
				end
			end else if (hit_q && !oob_q && done_c) begin
				valid_q[match_idx_q] <= 1'b0;
			end
		end
	end

	// commit: table payload
	always_ff @(posedge clk) begin
		if (cmd.commit) begin
			if (func_q == FUNC_HEADER) begin
				if (!hit_q) begin
					id_mem_q[free_idx_q]     <= id_q;
					size_mem_q[free_idx_q]   <= tsize_q;
					filled_mem_q[free_idx_q] <= '0;
				end
			end else if (hit_q && !oob_q) begin
				filled_mem_q[match_idx_q] <= nf_c;
			end
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.commit) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.commit) begin
			evicted_q <= 1'b0;
			evid_q    <= '0;
			woff_q    <= '0;
			if (func_q == FUNC_HEADER) begin
				evicted_q <= evict_q;
				evid_q    <= evict_q ? min_id_q : '0;
				if (hit_q) begin
					status_q     <= ST_DUP;
					slot_q       <= SLOT_W'(match_idx_q);
					filled_out_q <= filled_q;
					size_out_q   <= size_q;
				end else begin
					status_q     <= ST_OPENED;
					slot_q       <= SLOT_W'(free_idx_q);
					filled_out_q <= '0;
					size_out_q   <= tsize_q;
				end
			end else if (!hit_q) begin
				status_q     <= ST_UNKNOWN;
				slot_q       <= '0;
				filled_out_q <= '0;
				size_out_q   <= '0;
			end else begin
				slot_q     <= SLOT_W'(match_idx_q);
				woff_q     <= foff_q;
				size_out_q <= size_q;
				if (oob_q) begin
					status_q     <= ST_OOB;
					filled_out_q <= filled_q;
				end else begin
					status_q     <= done_c ? ST_COMPLETE : ST_PARTIAL;
					filled_out_q <= nf_c;
				end
			end
		end
	end

	assign sts.out_free = !out_valid_q || out_ready;

	assign out_valid    = out_valid_q;
	assign status       = status_q;
	assign slot         = slot_q;
	assign write_offset = woff_q;
	assign evicted      = evicted_q;
	assign evicted_id   = evid_q;
	assign filled_count = filled_out_q;
	assign message_size = size_out_q;

endmodule

FILE: hw/rtl/fragment_reassembly_tracker_top.sv
// Top level of the datagram fragment reassembly tracker.
//
// Input channel (in_valid/in_ready): one item is a header (func 0, opens an
// entry of total_size bytes for msg_id) or a fragment (func 1, adds
// payload_len bytes at frag_offset to the entry for msg_id).
// Output channel (out_valid/out_ready): exactly one result item per input
// item, in order: status, slot, write_offset, eviction report, filled count
// and message size of the entry touched.
//
// Each item is accepted, then scanned: the id scan visits one table entry
// per cycle and finds the matching entry and the smallest id at once. An
// evaluate state and a commit state follow; the commit waits until the
// output register is free. The next item is accepted in the cycle after the
// commit, so a new item is taken only once the last is through, as the scan
// walks the table entries one at a time.
//
// Reset clears all entry valid bits and the output valid bit; ids, sizes and
// counts are written before they are ever read. A result waiting in the
// output register does not block the next item: it is accepted and scanned
// while the receiver stalls, and only its commit waits for the register.
module fragment_reassembly_tracker_top (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            in_valid,
	output logic                            in_ready,
	input  logic                            func,
	input  logic [frt_pkg::ID_W-1:0]        msg_id,
	input  logic [frt_pkg::SIZE_W-1:0]      total_size,
	input  logic [frt_pkg::SIZE_W-1:0]      frag_offset,
	input  logic [frt_pkg::LEN_W-1:0]       payload_len,
	output logic                            out_valid,
	input  logic                            out_ready,
	output logic [frt_pkg::STATUS_W-1:0]    status,
	output logic [frt_pkg::SLOT_W-1:0]      slot,
	output logic [frt_pkg::SIZE_W-1:0]      write_offset,
	output logic                            evicted,
	output logic [frt_pkg::ID_W-1:0]        evicted_id,
	output logic [frt_pkg::SIZE_W-1:0]      filled_count,
	output logic [frt_pkg::SIZE_W-1:0]      message_size
);
	import frt_pkg::*;

	// command and status between sequencer and datapath
	cmd_t cmd;
	sts_t sts;

	frt_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	frt_datapath u_datapath (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.sts          (sts),
		.func         (func),
		.msg_id       (msg_id),
		.total_size   (total_size),
		.frag_offset  (frag_offset),
		.payload_len  (payload_len),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.status       (status),
		.slot         (slot),
		.write_offset (write_offset),
		.evicted      (evicted),
		.evicted_id   (evicted_id),
		.filled_count (filled_count),
		.message_size (message_size)
	);

endmodule

FILE: hw/rtl/frt_checker.sv
// Port-level checks on the tracker's result items, bound to the top level.
module frt_checker (
	input logic                            clk,
	input logic                            arst_n,
	input logic                            out_valid,
	input logic                            out_ready,
	input logic [frt_pkg::STATUS_W-1:0]    status,
	input logic [frt_pkg::SLOT_W-1:0]      slot,
	input logic [frt_pkg::SIZE_W-1:0]      write_offset,
	input logic                            evicted,
	input logic [frt_pkg::ID_W-1:0]        evicted_id,
	input logic [frt_pkg::SIZE_W-1:0]      filled_count,
	input logic [frt_pkg::SIZE_W-1:0]      message_size
);
	import frt_pkg::*;

	// stalled result holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(status) && $stable(slot) &&
		$stable(filled_count))
		else $error("result changed while stalled");

	a_code: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> status == ST_OPENED || status == ST_DUP || status == ST_PARTIAL ||
		status == ST_COMPLETE || status == ST_UNKNOWN || status == ST_OOB)
		else $error("undefined status code");

	a_unknown: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status == ST_UNKNOWN |-> slot == '0 && write_offset == '0 &&
		filled_count == '0 && message_size == '0)
		else $error("unknown fragment carries entry data");

	a_evict: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status != ST_OPENED && status != ST_DUP |-> !evicted &&
		evicted_id == '0)
		else $error("fragment reports an eviction");

	a_open: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status == ST_OPENED |-> filled_count == '0 && write_offset == '0)
		else $error("opened entry not empty");

endmodule

bind fragment_reassembly_tracker_top frt_checker u_frt_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.out_valid    (out_valid),
	.out_ready    (out_ready),
	.status       (status),
	.slot         (slot),
	.write_offset (write_offset),
	.evicted      (evicted),
	.evicted_id   (evicted_id),
	.filled_count (filled_count),
	.message_size (message_size)
);

FILE: test/tb_top.sv
// Testbench for the fragment reassembly tracker: table scoreboard, stimulus and result checks.
`timescale 1ns / 1ps

typedef struct packed {
	logic                         func;
	logic [frt_pkg::ID_W-1:0]     msg_id;
	logic [frt_pkg::SIZE_W-1:0]   total_size;
	logic [frt_pkg::SIZE_W-1:0]   frag_offset;
	logic [frt_pkg::LEN_W-1:0]    payload_len;
} frag_item_t;

typedef struct packed {
	logic [frt_pkg::STATUS_W-1:0] status;
	logic [frt_pkg::SLOT_W-1:0]   slot;
	logic [frt_pkg::SIZE_W-1:0]   write_offset;
	logic                         evicted;
	logic [frt_pkg::ID_W-1:0]     evicted_id;
	logic [frt_pkg::SIZE_W-1:0]   filled_count;
	logic [frt_pkg::SIZE_W-1:0]   message_size;
} frag_result_t;

class reassembly_scoreboard;
	bit                         in_use[frt_pkg::TABLE_DEPTH];
	bit [frt_pkg::ID_W-1:0]     owner_id[frt_pkg::TABLE_DEPTH];
	bit [frt_pkg::SIZE_W-1:0]   msg_bytes[frt_pkg::TABLE_DEPTH];
	bit [frt_pkg::SIZE_W-1:0]   got_bytes[frt_pkg::TABLE_DEPTH];
	frag_result_t               table_outcomes[$];
	int                         errors;
	int                         checked;
	int                         evictions;
	int                         status_seen[8];

	function new();
		foreach (in_use[i]) in_use[i] = 1'b0;
		foreach (status_seen[i]) status_seen[i] = 0;
		errors = 0;
		checked = 0;
		evictions = 0;
	endfunction

	function int find_slot(bit [frt_pkg::ID_W-1:0] id);
		for (int i = 0; i < frt_pkg::TABLE_DEPTH; i++)
			if (in_use[i] && owner_id[i] == id)
				return i;
		return -1;
	endfunction

	// Apply one accepted item to the shadow table and queue the result it must produce.
	function void note_item(frag_item_t it);
		frag_result_t r;
		int used, hit, victim, free_idx;
		logic [frt_pkg::SIZE_W:0] reach, total;
		r = '0;
		if (it.func == frt_pkg::FUNC_HEADER) begin
			used = 0;
			victim = -1;
			foreach (in_use[i]) if (in_use[i]) used++;
			if (used >= frt_pkg::TABLE_DEPTH) begin
				foreach (in_use[i])
					if (in_use[i] && (victim < 0 || owner_id[i] < owner_id[victim]))
						victim = i;
				in_use[victim] = 1'b0;
				r.evicted = 1'b1;
				r.evicted_id = owner_id[victim];
				evictions++;
			end
			hit = find_slot(it.msg_id);
			if (hit >= 0) begin
				r.status = frt_pkg::ST_DUP;
				r.slot = frt_pkg::SLOT_W'(hit);
				r.filled_count = got_bytes[hit];
				r.message_size = msg_bytes[hit];
			end else begin
				free_idx = 0;
				for (int i = frt_pkg::TABLE_DEPTH - 1; i >= 0; i--)
					if (!in_use[i]) free_idx = i;
				in_use[free_idx] = 1'b1;
				owner_id[free_idx] = it.msg_id;
				msg_bytes[free_idx] = it.total_size;
				got_bytes[free_idx] = '0;
				r.status = frt_pkg::ST_OPENED;
				r.slot = frt_pkg::SLOT_W'(free_idx);
				r.message_size = it.total_size;
			end
		end else begin
			hit = find_slot(it.msg_id);
			if (hit < 0) begin
				r.status = frt_pkg::ST_UNKNOWN;
			end else begin
				reach = {1'b0, it.frag_offset} + (frt_pkg::SIZE_W + 1)'(it.payload_len);
				r.slot = frt_pkg::SLOT_W'(hit);
				r.write_offset = it.frag_offset;
				r.message_size = msg_bytes[hit];
				if (it.payload_len > frt_pkg::MAX_FRAGMENT || reach > {1'b0, msg_bytes[hit]}) begin
					r.status = frt_pkg::ST_OOB;
					r.filled_count = got_bytes[hit];
				end else begin
					total = {1'b0, got_bytes[hit]} + (frt_pkg::SIZE_W + 1)'(it.payload_len);
					got_bytes[hit] = total[frt_pkg::SIZE_W] ? '1 : total[frt_pkg::SIZE_W-1:0];
					r.filled_count = got_bytes[hit];
					if (got_bytes[hit] >= msg_bytes[hit]) begin
						in_use[hit] = 1'b0;
						r.status = frt_pkg::ST_COMPLETE;
					end else begin
						r.status = frt_pkg::ST_PARTIAL;
					end
				end
			end
		end
		table_outcomes = {table_outcomes, r};
	endfunction

	function void cmp_field(string name, logic [63:0] want, logic [63:0] got);
		if (want !== got) begin
			$display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
			errors++;
		end
	endfunction

	function void check_result(frag_result_t got);
		frag_result_t want;
		if (table_outcomes.size() == 0) begin
			$display("%0t: result with no item outstanding, actual status %0d slot %0d",
				$time, got.status, got.slot);
			errors++;
			return;
		end
		want = table_outcomes[0];
		table_outcomes.delete(0);
		checked++;
		status_seen[want.status]++;
		cmp_field("status", want.status, got.status);
		cmp_field("slot", want.slot, got.slot);
		cmp_field("write_offset", want.write_offset, got.write_offset);
		cmp_field("evicted", want.evicted, got.evicted);
		cmp_field("evicted_id", want.evicted_id, got.evicted_id);
		cmp_field("filled_count", want.filled_count, got.filled_count);
		cmp_field("message_size", want.message_size, got.message_size);
	endfunction
endclass

module tb_top;
	import frt_pkg::*;

	localparam int CYCLE_LIMIT   = 1000000;
	localparam int HOLD_CYCLES   = 400;   // long receiver hold-off, fills the block
	localparam int RANDOM_BLOCKS = 12;
	localparam int BLOCK_ITEMS   = 100;
	localparam int LIVE_MAX      = 24;
	localparam int TAIL_CYCLES   = 3 * (TABLE_DEPTH + 3);

	typedef enum int {RDY_ALWAYS, RDY_COIN, RDY_SPARSE, RDY_PERIODIC} ready_mode_t;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 in_valid = 1'b0;
	logic                 in_ready;
	logic                 func = 1'b0;
	logic [ID_W-1:0]      msg_id = '0;
	logic [SIZE_W-1:0]    total_size = '0;
	logic [SIZE_W-1:0]    frag_offset = '0;
	logic [LEN_W-1:0]     payload_len = '0;
	logic                 out_valid;
	logic                 out_ready = 1'b0;
	logic [STATUS_W-1:0]  status;
	logic [SLOT_W-1:0]    slot;
	logic [SIZE_W-1:0]    write_offset;
	logic                 evicted;
	logic [ID_W-1:0]      evicted_id;
	logic [SIZE_W-1:0]    filled_count;
	logic [SIZE_W-1:0]    message_size;

	reassembly_scoreboard tracker = new();

	// Messages the stimulus believes are still open, used to build well-formed fragments.
	bit [ID_W-1:0]   live_id[LIVE_MAX];
	bit [SIZE_W-1:0] live_size[LIVE_MAX];
	bit [SIZE_W-1:0] live_next[LIVE_MAX];
	int              live_cnt = 0;

	int  items_sent = 0;
	int  directed_items = 0;
	int  cycle_count = 0;
	bit  hold_request = 1'b0;

	fragment_reassembly_tracker_top u_top (.*);

	always #6 clk = ~clk;

	// Hard stop so a hung handshake or a lost result cannot run forever.
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("%0t: timeout after %0d cycles, %0d results still outstanding",
				$time, cycle_count, tracker.table_outcomes.size());
			$display("** fragment_reassembly_tracker_top: FAILED **");
			$finish;
		end
	end

	// Check results at the falling edge: the values seen here are the ones
	// the next rising edge accepts, with no race against the block's updates.
	always @(negedge clk) begin : watch_results
		frag_result_t got;
		if (arst_n && out_valid && out_ready) begin
			got.status = status;
			got.slot = slot;
			got.write_offset = write_offset;
			got.evicted = evicted;
			got.evicted_id = evicted_id;
			got.filled_count = filled_count;
			got.message_size = message_size;
			tracker.check_result(got);
		end
	end

	// Receiver: stretches of different ready patterns, plus a long hold-off on request.
	initial begin : receiver
		ready_mode_t mode;
		int stretch, phase;
		mode = RDY_ALWAYS;
		stretch = 0;
		phase = 0;
		wait (arst_n === 1'b1);
		forever begin
			@(posedge clk);
			if (hold_request) begin
				out_ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
				hold_request = 1'b0;
			end else begin
				if (stretch == 0) begin
					mode = ready_mode_t'($urandom_range(0, 3));
					stretch = $urandom_range(20, 200);
				end
				stretch--;
				phase++;
				case (mode)
					RDY_ALWAYS:   out_ready <= 1'b1;
					RDY_COIN:     out_ready <= 1'($urandom_range(0, 1));
					RDY_SPARSE:   out_ready <= ($urandom_range(0, 3) == 0);
					default:      out_ready <= ((phase % 7) < 3);
				endcase
			end
		end
	end

	// Offer one item and hold it until accepted. Called at a rising edge;
	// returns at the rising edge that accepts the item.
	task automatic send_item(input frag_item_t it);
		in_valid <= 1'b1;
		func <= it.func;
		msg_id <= it.msg_id;
		total_size <= it.total_size;
		frag_offset <= it.frag_offset;
		payload_len <= it.payload_len;
		do @(negedge clk); while (!in_ready);
		tracker.note_item(it);
		items_sent++;
		@(posedge clk);
	endtask

	task automatic send_header(input logic [ID_W-1:0] id, input logic [SIZE_W-1:0] size);
		frag_item_t it;
		it = '0;
		it.func = FUNC_HEADER;
		it.msg_id = id;
		it.total_size = size;
		send_item(it);
	endtask

	task automatic send_fragment(input logic [ID_W-1:0] id, input logic [SIZE_W-1:0] off,
			input logic [LEN_W-1:0] len);
		frag_item_t it;
		it = '0;
		it.func = FUNC_FRAG;
		it.msg_id = id;
		it.frag_offset = off;
		it.payload_len = len;
		send_item(it);
	endtask

	task automatic idle_cycles(input int n);
		if (n > 0) begin
			in_valid <= 1'b0;
			repeat (n) @(posedge clk);
		end
	endtask

	// Pause the sender until every queued result has come back.
	task automatic wait_drained();
		in_valid <= 1'b0;
		while (tracker.table_outcomes.size() != 0) @(posedge clk);
	endtask

	task automatic track_message(input bit [ID_W-1:0] id, input bit [SIZE_W-1:0] size);
		int k;
		if (live_cnt < LIVE_MAX) begin
			k = live_cnt;
			live_cnt++;
		end else begin
			k = $urandom_range(0, LIVE_MAX - 1);
		end
		live_id[k] = id;
		live_size[k] = size;
		live_next[k] = '0;
	endtask

	// Mostly well-formed traffic: headers for fresh messages and in-order fragments
	// that fill them, with a share of noise (duplicates, strays, out-of-bounds).
	task automatic pick_random_item(input int hdr_pct, output frag_item_t it);
		int roll, k;
		bit [SIZE_W-1:0] remain;
		bit [ID_W-1:0] id;
		it = '0;
		roll = $urandom_range(0, 99);
		k = (live_cnt > 0) ? $urandom_range(0, live_cnt - 1) : 0;
		if (roll < 12) begin
			case ($urandom_range(0, 4))
				0: begin
					it.func = 1'($urandom_range(0, 1));
					it.msg_id = {$urandom, $urandom};
					it.total_size = $urandom;
					it.frag_offset = $urandom;
					it.payload_len = LEN_W'($urandom_range(0, 32767));
				end
				1: begin
					it.func = FUNC_HEADER;
					it.msg_id = (live_cnt > 0) ? live_id[k] : {$urandom, $urandom};
					it.total_size = $urandom_range(0, 70000);
				end
				2: begin
					it.func = FUNC_FRAG;
					it.msg_id = (live_cnt > 0) ? live_id[k] : {$urandom, $urandom};
					if ($urandom_range(0, 1) == 0) begin
						// run past the end of the message
						it.frag_offset = live_size[k] - $urandom_range(0, 100);
						it.payload_len = LEN_W'($urandom_range(101, MAX_FRAGMENT));
					end else begin
						it.payload_len = LEN_W'($urandom_range(MAX_FRAGMENT + 1, 32767));
					end
				end
				3: begin
					it.func = FUNC_FRAG;
					it.msg_id = {$urandom, $urandom};
					it.frag_offset = $urandom;
					it.payload_len = LEN_W'($urandom_range(0, MAX_FRAGMENT));
				end
				default: begin
					// low ids collide often and are the first evicted
					it.func = FUNC_HEADER;
					it.msg_id = 64'($urandom_range(0, 31));
					it.total_size = $urandom_range(0, 40000);
					track_message(it.msg_id, it.total_size);
				end
			endcase
		end else if (live_cnt == 0 || roll < 12 + hdr_pct) begin
			id = ($urandom_range(0, 7) == 0) ? 64'($urandom_range(0, 255)) : {$urandom, $urandom};
			it.func = FUNC_HEADER;
			it.msg_id = id;
			case ($urandom_range(0, 19))
				0:       it.total_size = '0;
				1:       it.total_size = $urandom;
				default: it.total_size = $urandom_range(1, 50000);
			endcase
			track_message(id, it.total_size);
		end else begin
			remain = live_size[k] - live_next[k];
			it.func = FUNC_FRAG;
			it.msg_id = live_id[k];
			if (remain > MAX_FRAGMENT)
				it.payload_len = ($urandom_range(0, 3) == 0) ? LEN_W'(MAX_FRAGMENT)
					: LEN_W'($urandom_range(1, MAX_FRAGMENT));
			else if ($urandom_range(0, 7) == 0)
				it.payload_len = LEN_W'($urandom_range(0, remain));
			else
				it.payload_len = LEN_W'(remain);
			// now and then resend bytes already covered
			if ($urandom_range(0, 9) == 0 && live_next[k] > 0)
				it.frag_offset = $urandom_range(0, live_next[k] - 1);
			else
				it.frag_offset = live_next[k];
			live_next[k] = live_next[k] + it.payload_len;
			if (live_next[k] >= live_size[k]) begin
				live_cnt--;
				live_id[k] = live_id[live_cnt];
				live_size[k] = live_size[live_cnt];
				live_next[k] = live_next[live_cnt];
			end
		end
	endtask

	initial begin : stimulus
		frag_item_t it;
		int hdr_pct, burst, in_block;

		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: stray fragment on an empty table, all fields at their top values.
		send_fragment('1, '1, '1);
		// Fill the table: a zero-size message, the largest id and size, and filler.
		send_header('0, '0);
		send_header('1, '1);
		send_header(64'd5, 32'd100);
		for (int i = 0; i < TABLE_DEPTH - 3; i++)
			send_header(64'h100 + i, 32'd1000 + i);
		// Full table: evict the smallest id, which is the id being opened again.
		send_header('0, 32'd7);
		// Full table again: eviction, then the id is already present.
		send_header(64'd5, 32'd9);
		// Offset plus length just past the largest size, then exactly to its end.
		send_fragment('1, '1, 15'd1);
		send_fragment('1, 32'hFFFF_BFFF, LEN_W'(MAX_FRAGMENT));
		// Length one above the fragment limit.
		send_fragment('1, '0, LEN_W'(MAX_FRAGMENT + 1));
		// Overlapping fragments that together reach the size.
		send_fragment(64'd5, 32'd0, 15'd60);
		send_fragment(64'd5, 32'd40, 15'd60);
		// Zero-size message completes on its first in-bounds fragment.
		send_header('0, '0);
		send_fragment('0, '0, '0);
		// Plain duplicate with room in the table.
		send_header('1, 32'd3);
		directed_items = items_sent;
		wait_drained();

		// Random: blocks with different header shares, bursts with random gaps.
		for (int blk = 0; blk < RANDOM_BLOCKS; blk++) begin
			hdr_pct = $urandom_range(10, 60);
			if (blk == 2 || blk == 8)
				hold_request = 1'b1;
			if (blk == 5)
				wait_drained();
			in_block = 0;
			while (in_block < BLOCK_ITEMS) begin
				burst = $urandom_range(1, 30);
				repeat (burst) begin
					pick_random_item(hdr_pct, it);
					send_item(it);
					in_block++;
				end
				idle_cycles(($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 50));
			end
		end

		// Drain, then leave room for any stray result to show up.
		wait_drained();
		repeat (TAIL_CYCLES) @(posedge clk);

		$display("Ran %0d items (%0d directed), %0d results checked: opened %0d, duplicate %0d,"
			, items_sent, directed_items, tracker.checked, tracker.status_seen[ST_OPENED],
			tracker.status_seen[ST_DUP]);
		$display("partial %0d, complete %0d, unknown %0d, out of bounds %0d, evictions %0d",
			tracker.status_seen[ST_PARTIAL], tracker.status_seen[ST_COMPLETE],
			tracker.status_seen[ST_UNKNOWN], tracker.status_seen[ST_OOB], tracker.evictions);
		if (tracker.errors == 0)
			$display("** fragment_reassembly_tracker_top: PASSED **");
		else
			$display("** fragment_reassembly_tracker_top: FAILED **");
		$finish;
	end

endmodule
